@@ design/hcc_pkg.sv @@
// Shared types and constants for the HSV cell color classifier.
// Used by hcc_pixel_match, hcc_cell_count and hsv_cell_color_classifier_unit.
package hcc_pkg;

  localparam int PixW   = 8;   // hue, sat and val width
  localparam int CountW = 14;  // pixel counter width
  localparam int CountLimit = (1 << CountW) - 1;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_RED_BAND_A = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RED_BAND_B = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RED_SAT    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RED_VAL    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BLUE_BAND  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BLUE_SAT   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_BLUE_VAL   = 3'd6;

  // Register values after reset
  localparam logic [15:0] RST_RED_BAND_A = 16'd45971;
  localparam logic [15:0] RST_RED_BAND_B = 16'd2560;
  localparam logic [7:0]  RST_RED_SAT    = 8'd96;
  localparam logic [7:0]  RST_RED_VAL    = 8'd80;
  localparam logic [15:0] RST_BLUE_BAND  = 16'd29031;
  localparam logic [7:0]  RST_BLUE_SAT   = 8'd98;
  localparam logic [7:0]  RST_BLUE_VAL   = 8'd137;

  typedef enum logic [1:0] {
    CLASS_EMPTY = 2'd0,
    CLASS_BLUE  = 2'd1,
    CLASS_RED   = 2'd2
  } hcc_class_t;

  // Hue band: low bound in [7:0], high bound in [15:8]
  typedef struct packed {
    logic [PixW-1:0] hi;
    logic [PixW-1:0] lo;
  } hcc_band_t;

  typedef struct packed {
    hcc_band_t       red_band_a;
    hcc_band_t       red_band_b;
    logic [PixW-1:0] red_sat_min;
    logic [PixW-1:0] red_val_min;
    hcc_band_t       blue_band;
    logic [PixW-1:0] blue_sat_min;
    logic [PixW-1:0] blue_val_min;
  } hcc_cfg_t;

  typedef struct packed {
    logic is_blue;
    logic is_red;
  } hcc_match_t;

endpackage

@@ design/hcc_pixel_match.sv @@
// Per-pixel color test: blue band and two red bands with sat/val floors.
// Depends on hcc_pkg.
module hcc_pixel_match (
  input  logic [hcc_pkg::PixW-1:0] hue,
  input  logic [hcc_pkg::PixW-1:0] sat,
  input  logic [hcc_pkg::PixW-1:0] val,
  input  hcc_pkg::hcc_cfg_t        cfg,
  output hcc_pkg::hcc_match_t      match
);
  import hcc_pkg::*;

  logic in_blue, in_red_a, in_red_b;

  // inclusive bounds; an inverted band matches nothing
  assign in_blue  = (hue >= cfg.blue_band.lo)  && (hue <= cfg.blue_band.hi);
  assign in_red_a = (hue >= cfg.red_band_a.lo) && (hue <= cfg.red_band_a.hi);
  assign in_red_b = (hue >= cfg.red_band_b.lo) && (hue <= cfg.red_band_b.hi);

  assign match.is_blue = in_blue && (sat >= cfg.blue_sat_min) && (val >= cfg.blue_val_min);
  assign match.is_red  = (in_red_a || in_red_b) &&
                         (sat >= cfg.red_sat_min) && (val >= cfg.red_val_min);

endmodule

@@ design/hcc_cell_count.sv @@
// Saturating pixel counters and the end-of-cell 20 percent decision.
// Depends on hcc_pkg.
module hcc_cell_count #(
  parameter int CELL_PIXELS_MAX = 8192
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                last,
  input  hcc_pkg::hcc_match_t match,
  output hcc_pkg::hcc_class_t cls
);
  import hcc_pkg::*;

  localparam int CapInt = (CELL_PIXELS_MAX > CountLimit) ? CountLimit : CELL_PIXELS_MAX;
  localparam logic [CountW-1:0] Cap = CountW'(CapInt);

  logic [CountW-1:0] total_pixels, blue_pixels, red_pixels;
  logic [CountW-1:0] total_next, blue_next, red_next;
  logic [CountW+2:0] blue_x5, red_x5, total_ext;

  // saturating increments
  always_comb begin
    total_next = (total_pixels < Cap) ? total_pixels + 1'b1 : Cap;
    blue_next  = blue_pixels;
    red_next   = red_pixels;
    if (match.is_blue) begin
      blue_next = (blue_pixels < Cap) ? blue_pixels + 1'b1 : Cap;
    end
    if (match.is_red) begin
      red_next = (red_pixels < Cap) ? red_pixels + 1'b1 : Cap;
    end
  end

  // 5*count > total, on the counts that include this pixel
  assign blue_x5   = {1'b0, blue_next, 2'b00} + {3'b000, blue_next};
  assign red_x5    = {1'b0, red_next, 2'b00} + {3'b000, red_next};
  assign total_ext = {3'b000, total_next};

  always_comb begin
    if (blue_x5 > total_ext) begin
      cls = CLASS_BLUE;
    end else if (red_x5 > total_ext) begin
      cls = CLASS_RED;
    end else begin
      cls = CLASS_EMPTY;
    end
  end

  // counters clear after the cell's last pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      total_pixels <= '0;
      blue_pixels  <= '0;
      red_pixels   <= '0;
    end else if (en) begin
      if (last) begin
        total_pixels <= '0;
        blue_pixels  <= '0;
        red_pixels   <= '0;
      end else begin
        total_pixels <= total_next;
        blue_pixels  <= blue_next;
        red_pixels   <= red_next;
      end
    end
  end

endmodule

@@ design/hsv_cell_color_classifier_unit.sv @@
// Top level of the HSV cell color classifier: config registers, pixel and result stages.
// Depends on hcc_pkg, hcc_pixel_match and hcc_cell_count.
//
// Takes one HSV pixel word per clock unless stalled and, on the word flagged by s_tlast,
// emits one class word (0 empty, 1 blue, 2 red) from the result register. A pixel is
// registered, then tested and counted from the input register. The only stall is a
// finished class word still waiting in the output register while the next flagged pixel
// reaches the counters. The user must see that configuration is written through cfg_we/
// cfg_index/cfg_data only while no pixel is in flight; the block does not enforce this.
module hsv_cell_color_classifier_unit #(
  parameter int CELL_PIXELS_MAX = 8192
) (
  input  logic                          clk,
  input  logic                          rst,
  // pixel stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,   // hue[7:0], sat[15:8], val[23:16]
  input  logic                          s_tlast,   // last_pixel
  // class stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // cell_class[1:0], zero above
  // configuration
  input  logic                          cfg_we,
  input  logic [hcc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [hcc_pkg::CfgDataW-1:0]  cfg_data
);
  import hcc_pkg::*;

  hcc_cfg_t        cfg;
  logic            pix_valid;
  logic            pix_last;
  logic [PixW-1:0] pix_hue, pix_sat, pix_val;
  logic            advance;
  hcc_match_t      match;
  hcc_class_t      cls;
  hcc_class_t      out_class;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_band_a   <= RST_RED_BAND_A;
      cfg.red_band_b   <= RST_RED_BAND_B;
      cfg.red_sat_min  <= RST_RED_SAT;
      cfg.red_val_min  <= RST_RED_VAL;
      cfg.blue_band    <= RST_BLUE_BAND;
      cfg.blue_sat_min <= RST_BLUE_SAT;
      cfg.blue_val_min <= RST_BLUE_VAL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RED_BAND_A: cfg.red_band_a   <= cfg_data;
        REG_RED_BAND_B: cfg.red_band_b   <= cfg_data;
        REG_RED_SAT:    cfg.red_sat_min  <= cfg_data[PixW-1:0];
        REG_RED_VAL:    cfg.red_val_min  <= cfg_data[PixW-1:0];
        REG_BLUE_BAND:  cfg.blue_band    <= cfg_data;
        REG_BLUE_SAT:   cfg.blue_sat_min <= cfg_data[PixW-1:0];
        REG_BLUE_VAL:   cfg.blue_val_min <= cfg_data[PixW-1:0];
        default: ;
      endcase
    end
  end

  // a pixel moves on unless it would produce a word while the output is still full
  assign advance  = pix_valid && (!pix_last || !m_tvalid || m_tready);
  assign s_tready = !pix_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (s_tready) begin
      pix_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pix_hue  <= s_tdata[7:0];
      pix_sat  <= s_tdata[15:8];
      pix_val  <= s_tdata[23:16];
      pix_last <= s_tlast;
    end
  end

  hcc_pixel_match u_match (
    .hue   (pix_hue),
    .sat   (pix_sat),
    .val   (pix_val),
    .cfg   (cfg),
    .match (match)
  );

  hcc_cell_count #(
    .CELL_PIXELS_MAX (CELL_PIXELS_MAX)
  ) u_count (
    .clk   (clk),
    .rst   (rst),
    .en    (advance),
    .last  (pix_last),
    .match (match),
    .cls   (cls)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && pix_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pix_last) begin
      out_class <= cls;
    end
  end

  assign m_tdata = {6'b000000, out_class};

  // checks
  a_no_bad_class: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3))
    else $error("class code 3 on output");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !advance) |-> (m_tvalid && !m_tready && pix_last))
    else $error("pixel stage stalled without a blocked output word");

  a_last_gives_word: assert property (@(posedge clk) disable iff (rst)
    (advance && pix_last) |=> m_tvalid)
    else $error("last pixel did not produce a class word");

endmodule

@@ test/hsv_cell_color_classifier_unit_test.sv @@
`timescale 1ns / 100ps
// Testbench for hsv_cell_color_classifier_unit: streams HSV pixel words in regions,
// predicts the class word of each flagged region and checks every class word in order.
// Depends on hcc_pkg and the classifier RTL under design/.
module hsv_cell_color_classifier_unit_test;
  import hcc_pkg::*;

  localparam int CELL_PIXELS_MAX = 8192;
  localparam int COUNT_CAP = (CELL_PIXELS_MAX > CountLimit) ? CountLimit : CELL_PIXELS_MAX;
  localparam int RAND_PIXELS = 150;     // pixels per random phase
  localparam int SETTLE_CYCLES = 8;     // pipeline is two deep, leave some margin
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

  // Region tallies, register shadow and queue of expected class words
  class cell_tally;
    hcc_cfg_t cfg;
    logic [CountW-1:0] total_cnt;
    logic [CountW-1:0] blue_cnt;
    logic [CountW-1:0] red_cnt;
    hcc_class_t pending_classes[$];
    int errors;

    function new();
      cfg.red_band_a   = RST_RED_BAND_A;
      cfg.red_band_b   = RST_RED_BAND_B;
      cfg.red_sat_min  = RST_RED_SAT;
      cfg.red_val_min  = RST_RED_VAL;
      cfg.blue_band    = RST_BLUE_BAND;
      cfg.blue_sat_min = RST_BLUE_SAT;
      cfg.blue_val_min = RST_BLUE_VAL;
      total_cnt = '0;
      blue_cnt = '0;
      red_cnt = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_RED_BAND_A: cfg.red_band_a = data;
        REG_RED_BAND_B: cfg.red_band_b = data;
        REG_RED_SAT:    cfg.red_sat_min = data[7:0];
        REG_RED_VAL:    cfg.red_val_min = data[7:0];
        REG_BLUE_BAND:  cfg.blue_band = data;
        REG_BLUE_SAT:   cfg.blue_sat_min = data[7:0];
        REG_BLUE_VAL:   cfg.blue_val_min = data[7:0];
        default: ;  // no such register, write dropped
      endcase
    endfunction

    // Inclusive band test; an inverted band matches nothing
    function bit in_band(hcc_band_t band, logic [7:0] hue);
      return (hue >= band.lo) && (hue <= band.hi);
    endfunction

    function logic [CountW-1:0] bump(logic [CountW-1:0] cnt);
      return (cnt < COUNT_CAP) ? cnt + 1'b1 : CountW'(COUNT_CAP);
    endfunction

    // Count one accepted pixel; a flagged pixel closes the region
    function void take_pixel(logic [7:0] hue, logic [7:0] sat, logic [7:0] val, logic last);
      bit blue_hit;
      bit red_hit;
      blue_hit = in_band(cfg.blue_band, hue) && sat >= cfg.blue_sat_min &&
                 val >= cfg.blue_val_min;
      red_hit = (in_band(cfg.red_band_a, hue) || in_band(cfg.red_band_b, hue)) &&
                sat >= cfg.red_sat_min && val >= cfg.red_val_min;
      total_cnt = bump(total_cnt);
      if (blue_hit) blue_cnt = bump(blue_cnt);
      if (red_hit) red_cnt = bump(red_cnt);
      if (last) begin
        // more than a fifth of the region, blue checked first
        if (5 * int'(blue_cnt) > int'(total_cnt)) pending_classes.push_back(CLASS_BLUE);
        else if (5 * int'(red_cnt) > int'(total_cnt)) pending_classes.push_back(CLASS_RED);
        else pending_classes.push_back(CLASS_EMPTY);
        total_cnt = '0;
        blue_cnt = '0;
        red_cnt = '0;
      end
    endfunction

    function void check_word(logic [7:0] word);
      hcc_class_t want;
      if (pending_classes.size() == 0) begin
        $error("cell_class: expected no word, got %0d", word[1:0]);
        errors++;
        return;
      end
      want = pending_classes.pop_front();
      if (word[1:0] !== want) begin
        $error("cell_class: expected %0d, got %0d", want, word[1:0]);
        errors++;
      end
      if (word[7:2] !== '0) begin
        $error("pad: expected 0, got %0h", word[7:2]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;   // hue[7:0], sat[15:8], val[23:16]
  logic s_tlast = 1'b0;        // last_pixel
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;         // cell_class[1:0], zero above
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  cell_tally tally;
  int unsigned cycle_count = 0;
  int burst_left = 0;
  bit valid_up = 1'b0;
  int ready_run = 0;
  logic ready_level = 1'b1;

  hsv_cell_color_classifier_unit #(
    .CELL_PIXELS_MAX(CELL_PIXELS_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Class word sink: long ready stretches, short stalls, and choppy spells
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tally.check_word(m_tdata);
    if (ready_run == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          ready_level = 1'b1;
          ready_run = $urandom_range(20, 60);
        end
        1: begin
          ready_level = 1'b0;
          ready_run = $urandom_range(1, 8);
        end
        default: begin
          ready_level = $urandom_range(0, 1);
          ready_run = $urandom_range(1, 4);
        end
      endcase
    end
    ready_run--;
    m_tready <= ready_level;
  end

  // Offer one pixel word until taken; bursts end in a random gap
  task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                            input logic [7:0] val, input logic last);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= {val, sat, hue};
    s_tlast <= last;
    valid_up = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tally.take_pixel(hue, sat, val, last);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      valid_up = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (valid_up) begin
      s_tvalid <= 1'b0;
      valid_up = 1'b0;
    end
    while (tally.pending_classes.size() != 0) @(posedge clk);
  endtask

  // Idle point for register writes: nothing owed and no unflagged pixel in flight
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    tally.set_reg(idx, data);
  endtask

  task automatic load_settings(input logic [15:0] red_a, input logic [15:0] red_b,
                               input logic [15:0] red_sat, input logic [15:0] red_val,
                               input logic [15:0] blue, input logic [15:0] blue_sat,
                               input logic [15:0] blue_val);
    write_reg(REG_RED_BAND_A, red_a);
    write_reg(REG_RED_BAND_B, red_b);
    write_reg(REG_RED_SAT, red_sat);
    write_reg(REG_RED_VAL, red_val);
    write_reg(REG_BLUE_BAND, blue);
    write_reg(REG_BLUE_SAT, blue_sat);
    write_reg(REG_BLUE_VAL, blue_val);
    cfg_we <= 1'b0;
  endtask

  // Mostly ordered bands, a quarter inverted
  function automatic logic [15:0] rand_band();
    int lo;
    int hi;
    if ($urandom_range(0, 3) != 0) begin
      lo = $urandom_range(0, 200);
      hi = lo + $urandom_range(0, 55);
    end else begin
      hi = $urandom_range(0, 150);
      lo = hi + 1 + $urandom_range(0, 100);
    end
    return {hi[7:0], lo[7:0]};
  endfunction

  // Junk in the upper byte must be dropped by the 8-bit registers
  function automatic logic [15:0] rand_min();
    return {8'($urandom), 8'($urandom_range(0, 200))};
  endfunction

  // tilt: 0 mostly blue, 1 mostly red, 2 mixed, 3 noise
  task automatic pick_pixel(input int tilt, output logic [7:0] hue,
                            output logic [7:0] sat, output logic [7:0] val);
    hcc_band_t band;
    logic [7:0] sat_min;
    logic [7:0] val_min;
    int kind;
    int aim;
    kind = $urandom_range(0, 9);
    case (tilt)
      0: aim = (kind < 7) ? 1 : 0;
      1: aim = (kind < 7) ? 2 : 0;
      2: aim = (kind < 3) ? 1 : (kind < 6) ? 2 : 0;
      default: aim = 0;
    endcase
    if (aim == 1) begin
      band = tally.cfg.blue_band;
      sat_min = tally.cfg.blue_sat_min;
      val_min = tally.cfg.blue_val_min;
    end else begin
      band = $urandom_range(0, 1) ? tally.cfg.red_band_a : tally.cfg.red_band_b;
      sat_min = tally.cfg.red_sat_min;
      val_min = tally.cfg.red_val_min;
    end
    if (aim != 0) begin
      hue = (band.lo <= band.hi) ? 8'($urandom_range(band.hi, band.lo))
                                 : 8'($urandom_range(0, 255));
      sat = 8'($urandom_range(255, sat_min));
      val = 8'($urandom_range(255, val_min));
    end else begin
      hue = $urandom_range(0, 1) ? 8'($urandom_range(0, 179)) : 8'($urandom_range(0, 255));
      sat = 8'($urandom);
      val = 8'($urandom);
    end
  endtask

  // Random regions, mostly short, with an occasional full drain
  task automatic run_regions(input int target);
    int sent;
    int len;
    int tilt;
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 48) : $urandom_range(1, 10);
      tilt = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        pick_pixel(tilt, hue, sat, val);
        send_pixel(hue, sat, val, i == len - 1);
      end
      sent += len;
      if ($urandom_range(0, 15) == 0) drain();
    end
  endtask

  initial begin
    tally = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Band and threshold edges under reset settings
    send_pixel(8'd103, 8'd98, 8'd137, 1'b1);
    send_pixel(8'd113, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd102, 8'd98, 8'd137, 1'b1);
    send_pixel(8'd114, 8'd98, 8'd137, 1'b1);
    send_pixel(8'd108, 8'd97, 8'd200, 1'b1);
    send_pixel(8'd108, 8'd200, 8'd136, 1'b1);
    send_pixel(8'd147, 8'd96, 8'd80, 1'b1);
    send_pixel(8'd179, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd146, 8'd96, 8'd80, 1'b1);
    send_pixel(8'd0, 8'd96, 8'd80, 1'b1);
    send_pixel(8'd10, 8'd96, 8'd80, 1'b1);
    send_pixel(8'd11, 8'd200, 8'd200, 1'b1);
    send_pixel(8'd160, 8'd95, 8'd200, 1'b1);
    send_pixel(8'd160, 8'd200, 8'd79, 1'b1);
    // hue past 179 is compared without wrap
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd180, 8'd255, 8'd255, 1'b1);
    // exactly a fifth is not enough
    send_pixel(8'd108, 8'd200, 8'd200, 1'b0);
    send_pixel(8'd50, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd50, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd50, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd50, 8'd0, 8'd0, 1'b1);
    // one in four is
    send_pixel(8'd170, 8'd200, 8'd200, 1'b0);
    send_pixel(8'd50, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd50, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd50, 8'd0, 8'd0, 1'b1);

    // All zero: every band is hue 0 only, no saturation or value floor
    settle();
    write_reg(REG_UNUSED, 16'hFFFF);
    load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_regions(RAND_PIXELS);

    // All ones: bands are hue 255 only, floors at 255
    settle();
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_regions(RAND_PIXELS);

    // Red band covers everything and overlaps blue; second red band inverted
    settle();
    load_settings(16'hFF00, 16'h32C8, 16'h0040, 16'h0030, 16'h8C50, 16'h0020, 16'h0010);
    run_regions(RAND_PIXELS);

    repeat (2) begin
      settle();
      load_settings(rand_band(), rand_band(), rand_min(), rand_min(),
                    rand_band(), rand_min(), rand_min());
      run_regions(RAND_PIXELS);
    end

    // Back to reset settings for the last phase
    settle();
    load_settings(RST_RED_BAND_A, RST_RED_BAND_B, RST_RED_SAT, RST_RED_VAL,
                  RST_BLUE_BAND, RST_BLUE_SAT, RST_BLUE_VAL);
    run_regions(RAND_PIXELS);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tally.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
